>>> hdl/can_link_watchdog_indicator_top_macros.svh
// assertion macros for the can link watchdog indicator
// used by can_link_watchdog_indicator_top, no other dependencies
`ifndef CAN_LINK_WATCHDOG_INDICATOR_TOP_MACROS_SVH
`define CAN_LINK_WATCHDOG_INDICATOR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define CLWI_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define CLWI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/clwi_pkg.sv
// types and constants for the can link watchdog indicator
// no dependencies, used by can_link_watchdog_indicator_top
package clwi_pkg;

   localparam int unsigned ID_W      = 29;
   localparam int unsigned REG_W     = 16;
   localparam int unsigned CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WATCHED_ID = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SILENCE_TO = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_HALF = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FLASH_ON   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FLASH_OFF  = 3'd4;

   // register reset values
   localparam logic [ID_W-1:0]  RST_WATCHED_ID = 29'h18FC_C321;
   localparam logic [REG_W-1:0] RST_SILENCE_TO = 16'd500;
   localparam logic [REG_W-1:0] RST_BLINK_HALF = 16'd400;
   localparam logic [REG_W-1:0] RST_FLASH_ON   = 16'd500;
   localparam logic [REG_W-1:0] RST_FLASH_OFF  = 16'd2500;

   // input opcodes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   // indicator modes
   localparam logic [1:0] MODE_DARK  = 2'd0;
   localparam logic [1:0] MODE_FLASH = 2'd1;
   localparam logic [1:0] MODE_BLINK = 2'd2;

   typedef struct packed {
      logic            op;
      logic [ID_W-1:0] frame_id;
      logic            frame_extended;
      logic            brake_bit;
      logic            hatch_bit;
      logic            bus_off;
   } req_word_type;

   typedef struct packed {
      logic       brake_relay;
      logic       hatch_out;
      logic       indicator;
      logic       link_alive;
      logic [1:0] indicator_mode;
   } rsp_word_type;

endpackage

>>> hdl/can_link_watchdog_indicator_top.sv
// can link watchdog with status lamp, top level
// depends on clwi_pkg and can_link_watchdog_indicator_top_macros.svh
//
// usage
//   req channel: one word per event, op selects a millisecond tick or a
//   received frame. rsp channel: exactly one word per req word, in order,
//   carrying relay, hatch, lamp, alive flag and lamp mode after that event.
//   csr port: plain write (enable, index, data), no read-back; write only
//   while the block is idle. unknown indexes are ignored.
// path and throughput
//   a word is captured in the input register, processed by one short pass
//   of compare and flag logic into the result register, where rsp_valid
//   rises with it. one word per cycle is taken when the receiver does not
//   stall; the rate is set by the single state update per cycle.
// reset
//   synchronous, active high. link not alive, both timers cleared, relay
//   energised (released), hatch low, lamp dark, flash in its on part,
//   registers back to their defaults.
// stall
//   a stalled result holds in the result register; one more word waits in
//   the input register, after which req_stall rises until rsp drains.
module can_link_watchdog_indicator_top #(
   parameter int unsigned TIMER_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  clwi_pkg::req_word_type            req_data,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output clwi_pkg::rsp_word_type            rsp_data,
   // configuration writes
   input  logic                              csr_write_en,
   input  logic [clwi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [clwi_pkg::ID_W-1:0]         csr_wdata
);
   import clwi_pkg::*;

`include "can_link_watchdog_indicator_top_macros.svh"

   // compare width covers both the timers and the 16 bit registers
   localparam int unsigned CMP_W = (TIMER_WIDTH > REG_W) ? TIMER_WIDTH : REG_W;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
   localparam logic [TIMER_WIDTH-1:0] TIMER_ONE = TIMER_WIDTH'(1);

   // configuration registers
   logic [ID_W-1:0]  watched_id_ff;
   logic [REG_W-1:0] silence_to_ff;
   logic [REG_W-1:0] blink_half_ff;
   logic [REG_W-1:0] flash_on_ff;
   logic [REG_W-1:0] flash_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         watched_id_ff <= RST_WATCHED_ID;
         silence_to_ff <= RST_SILENCE_TO;
         blink_half_ff <= RST_BLINK_HALF;
         flash_on_ff   <= RST_FLASH_ON;
         flash_off_ff  <= RST_FLASH_OFF;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_WATCHED_ID: watched_id_ff <= csr_wdata;
            REG_SILENCE_TO: silence_to_ff <= csr_wdata[REG_W-1:0];
            REG_BLINK_HALF: blink_half_ff <= csr_wdata[REG_W-1:0];
            REG_FLASH_ON:   flash_on_ff   <= csr_wdata[REG_W-1:0];
            REG_FLASH_OFF:  flash_off_ff  <= csr_wdata[REG_W-1:0];
            default: ;   // unknown index, write dropped
         endcase
      end
   end

   // pipeline control: the result stage moves when it is empty or drained
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;
   logic         advance;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_word_ff <= req_data;
      end
   end

   // watchdog state
   logic                   alive_ff,   alive_in;
   logic [TIMER_WIDTH-1:0] silence_ff, silence_in;
   logic [TIMER_WIDTH-1:0] pattern_ff, pattern_in;
   logic                   phase_ff,   phase_in;   // 0 on part, 1 off part
   logic                   blink_ff,   blink_in;
   logic                   relay_ff,   relay_in;
   logic                   hatch_ff,   hatch_in;
   logic                   lamp_ff,    lamp_in;
   rsp_word_type           rsp_word_in;

   // saturating timer increments
   logic [TIMER_WIDTH-1:0] silence_inc;
   logic [TIMER_WIDTH-1:0] pattern_inc;
   logic                   frame_match;
   logic                   timed_out;
   logic [1:0]             mode;

   assign silence_inc = (silence_ff == TIMER_MAX) ? silence_ff : silence_ff + TIMER_ONE;
   assign pattern_inc = (pattern_ff == TIMER_MAX) ? pattern_ff : pattern_ff + TIMER_ONE;
   assign frame_match = in_word_ff.frame_extended && (in_word_ff.frame_id == watched_id_ff);
   assign timed_out   = CMP_W'(silence_inc) >= CMP_W'(silence_to_ff);

   always_comb begin
      alive_in   = alive_ff;
      silence_in = silence_ff;
      pattern_in = pattern_ff;
      phase_in   = phase_ff;
      blink_in   = blink_ff;
      relay_in   = relay_ff;
      hatch_in   = hatch_ff;
      lamp_in    = lamp_ff;

      if (in_word_ff.op == OP_FRAME) begin
         // matching frame proves the link; lamp untouched
         if (frame_match) begin
            silence_in = '0;
            alive_in   = 1'b1;
         end
      end else begin
         silence_in = silence_inc;
         pattern_in = pattern_inc;
         if (alive_ff && timed_out) begin
            // link lost, fall back to the safe outputs
            alive_in = 1'b0;
            relay_in = 1'b1;
            hatch_in = 1'b0;
         end else if (alive_ff) begin
            relay_in = in_word_ff.brake_bit;
            hatch_in = in_word_ff.hatch_bit;
         end
      end

      // mode from bus-off and the updated alive flag
      if (in_word_ff.bus_off) begin
         mode = MODE_DARK;
      end else if (alive_in) begin
         mode = MODE_BLINK;
      end else begin
         mode = MODE_FLASH;
      end

      if (in_word_ff.op == OP_TICK) begin
         unique case (mode)
            MODE_DARK: begin
               lamp_in = 1'b0;
            end
            MODE_FLASH: begin
               if (!phase_ff) begin
                  if (CMP_W'(pattern_inc) >= CMP_W'(flash_on_ff)) begin
                     pattern_in = '0;
                     lamp_in    = 1'b0;
                     phase_in   = 1'b1;
                  end else begin
                     lamp_in = 1'b1;
                  end
               end else if (CMP_W'(pattern_inc) >= CMP_W'(flash_off_ff)) begin
                  pattern_in = '0;
                  lamp_in    = 1'b1;
                  phase_in   = 1'b0;
               end
            end
            MODE_BLINK: begin
               if (CMP_W'(pattern_inc) >= CMP_W'(blink_half_ff)) begin
                  pattern_in = '0;
                  blink_in   = !blink_ff;
                  lamp_in    = !blink_ff;
               end
            end
            default: ;
         endcase
      end

      rsp_word_in.brake_relay    = relay_in;
      rsp_word_in.hatch_out      = hatch_in;
      rsp_word_in.indicator      = lamp_in;
      rsp_word_in.link_alive     = alive_in;
      rsp_word_in.indicator_mode = mode;
   end

   // state commits only when a word actually moves into the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff     <= 1'b0;
         silence_ff   <= '0;
         pattern_ff   <= '0;
         phase_ff     <= 1'b0;
         blink_ff     <= 1'b0;
         relay_ff     <= 1'b1;
         hatch_ff     <= 1'b0;
         lamp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            alive_ff   <= alive_in;
            silence_ff <= silence_in;
            pattern_ff <= pattern_in;
            phase_ff   <= phase_in;
            blink_ff   <= blink_in;
            relay_ff   <= relay_in;
            hatch_ff   <= hatch_in;
            lamp_ff    <= lamp_in;
         end
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // a dead link always holds the safe outputs
   `CLWI_ASSERT_NOW(a_safe_when_lost, !alive_ff, relay_ff && !hatch_ff, "lost link not safe")
   // blink mode is only reported with the link alive
   `CLWI_ASSERT_NOW(a_blink_alive, rsp_valid_ff && (rsp_word_ff.indicator_mode == MODE_BLINK),
      rsp_word_ff.link_alive, "blink mode without live link")
   // a word leaving the input stage shows up as a result next cycle
   `CLWI_ASSERT_NEXT(a_stage_moves, in_valid_ff && advance, rsp_valid_ff, "word lost in pipeline")
   // back-pressure only while a word is parked
   `CLWI_ASSERT_NEXT(a_stall_holds, req_stall, in_valid_ff, "parked word dropped")

endmodule
